// ===== src/pl0_pkg.sv =====
package pl0_pkg;

   typedef enum logic [3:0] {
      KIND_LIT = 4'd0,
      KIND_OPR = 4'd1,
      KIND_LOD = 4'd2,
      KIND_STO = 4'd3,
      KIND_CAL = 4'd4,
      KIND_INT = 4'd5,
      KIND_JMP = 4'd6,
      KIND_JPC = 4'd7,
      KIND_RED = 4'd8,
      KIND_WRT = 4'd9
   } kind_type;

   localparam logic [2:0] ST_RUN      = 3'd0;
   localparam logic [2:0] ST_END      = 3'd1;
   localparam logic [2:0] ST_DIVZERO  = 3'd2;
   localparam logic [2:0] ST_OVERFLOW = 3'd3;
   localparam logic [2:0] ST_BADOP    = 3'd4;
   localparam logic [2:0] ST_RANGE    = 3'd5;

   localparam logic [31:0] OPR_RET = 32'd0;
   localparam logic [31:0] OPR_NEG = 32'd1;
   localparam logic [31:0] OPR_ADD = 32'd2;
   localparam logic [31:0] OPR_SUB = 32'd3;
   localparam logic [31:0] OPR_MUL = 32'd4;
   localparam logic [31:0] OPR_DIV = 32'd5;
   localparam logic [31:0] OPR_ODD = 32'd6;
   localparam logic [31:0] OPR_EQL = 32'd8;
   localparam logic [31:0] OPR_NEQ = 32'd9;
   localparam logic [31:0] OPR_LSS = 32'd10;
   localparam logic [31:0] OPR_GEQ = 32'd11;
   localparam logic [31:0] OPR_GTR = 32'd12;
   localparam logic [31:0] OPR_LEQ = 32'd13;

   typedef enum logic [3:0] {
      FSM_IDLE,
      FSM_CLEAR,
      FSM_WALK,
      FSM_RD1,
      FSM_RD2,
      FSM_MUL,
      FSM_DIV,
      FSM_CALW,
      FSM_LINK,
      FSM_RETB,
      FSM_FINISH,
      FSM_OUT
   } fsm_type;

endpackage

// ===== src/pl0_if.sv =====
interface pl0_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  kind;
   logic [7:0]  level;
   logic signed [31:0] address;
   logic signed [31:0] read_value;
   modport source (output valid, kind, level, address, read_value, input ready);
   modport sink (input valid, kind, level, address, read_value, output ready);
endinterface

interface pl0_rsp_if;
   logic        valid;
   logic        ready;
   logic [12:0] next_pc;
   logic        write_valid;
   logic signed [31:0] write_value;
   logic [2:0]  status;
   modport source (output valid, next_pc, write_valid, write_value, status, input ready);
   modport sink (input valid, next_pc, write_valid, write_value, status, output ready);
endinterface

interface pl0_csr_if;
   logic        valid;
   logic        ready;
   logic [12:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ===== src/pl0_pcode_stack_machine_top.sv =====
// P-code interpreter: one instruction per request transaction, one response each.
// Simple ops pass FINISH and OUT; the static-chain walk adds WALK and LINK per level,
// MUL adds FSM_MUL, DIV a bit-serial divide, CAL adds CALW. One instruction at a time.
// Reset: synchronous; afterwards the stack memory is zeroed by a clearing pass over all
// STACK_DEPTH words, during which no instruction is accepted.
module pl0_pcode_stack_machine_top #(
   parameter int STACK_DEPTH = 1024,
   parameter int CODE_DEPTH  = 4096
) (
   input  logic       clock,
   input  logic       reset,
   pl0_req_if.sink    req,
   pl0_rsp_if.source  rsp,
   pl0_csr_if.sink    csr
);
   localparam int AW = $clog2(STACK_DEPTH);
   localparam int TW = AW + 2;
   localparam int PW = 13;
   localparam logic signed [TW-1:0] SDEPTH = TW'(STACK_DEPTH);
   localparam logic [PW-1:0] CDEPTH = PW'(CODE_DEPTH);

   pl0_pkg::fsm_type state_ff, state_in;

   logic [PW-1:0] code_len_ff, code_len_in;
   logic signed [TW-1:0] top_ff, top_in;
   logic [AW-1:0] base_ff, base_in;
   logic [PW-1:0] pc_ff, pc_in;
   logic halted_ff, halted_in;

   logic [3:0]  kind_ff, kind_in;
   logic [7:0]  lv_ff, lv_in;
   logic [31:0] adr_ff, adr_in;
   logic [31:0] rv_ff, rv_in;
   logic [AW-1:0] wb_ff, wb_in;
   logic [31:0] x_ff, x_in;
   logic [31:0] y_ff, y_in;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] q_ff, q_in;
   logic [31:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [AW-1:0] clr_ff, clr_in;

   logic [PW-1:0] onpc_ff, onpc_in;
   logic owv_ff, owv_in;
   logic [31:0] owval_ff, owval_in;
   logic [2:0] ost_ff, ost_in;

   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [31:0] wr_data, rd_data;

   pl0_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   assign csr.ready = 1'b1;
   assign req.ready = (state_ff == pl0_pkg::FSM_IDLE);
   assign rsp.valid = (state_ff == pl0_pkg::FSM_OUT);
   assign rsp.next_pc = onpc_ff;
   assign rsp.write_valid = owv_ff;
   assign rsp.write_value = owval_ff;
   assign rsp.status = ost_ff;

   logic [PW-1:0] limit;
   assign limit = (code_len_ff < CDEPTH) ? code_len_ff : CDEPTH;

   function automatic logic [PW-1:0] tgt(input logic [31:0] v);
      if (!v[31] && v < 32'(CODE_DEPTH)) tgt = PW'(v);
      else tgt = PW'(CODE_DEPTH);
   endfunction

   // frame address helper: base + signed offset range check
   logic signed [33:0] faddr;
   logic faddr_ok;
   assign faddr = $signed({24'd0, wb_ff}) + $signed({{2{adr_ff[31]}}, adr_ff});
   assign faddr_ok = (faddr >= 0) && (faddr < 34'(STACK_DEPTH));

   logic signed [TW-1:0] tp1;
   assign tp1 = top_ff + TW'(1);

   logic slt_xy, slt_yx;
   assign slt_xy = $signed(x_ff) < $signed(y_ff);
   assign slt_yx = $signed(y_ff) < $signed(x_ff);

   logic [31:0] ma, mb;
   assign ma = x_ff[31] ? 32'(0 - x_ff) : x_ff;
   assign mb = y_ff[31] ? 32'(0 - y_ff) : y_ff;
   logic [32:0] rtrial;
   assign rtrial = {rem_ff, ma[cnt_ff[4:0]]} - {1'b0, mb};

   logic signed [33:0] nt;
   assign nt = $signed({{(34-TW){top_ff[TW-1]}}, top_ff}) + $signed({{2{adr_ff[31]}}, adr_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pl0_pkg::FSM_CLEAR;
         code_len_ff <= '0;
         top_ff <= '1;
         base_ff <= '0;
         pc_ff <= '0;
         halted_ff <= 1'b0;
         clr_ff <= '0;
      end else begin
         state_ff <= state_in;
         code_len_ff <= code_len_in;
         top_ff <= top_in;
         base_ff <= base_in;
         pc_ff <= pc_in;
         halted_ff <= halted_in;
         clr_ff <= clr_in;
      end
      kind_ff <= kind_in; lv_ff <= lv_in; adr_ff <= adr_in; rv_ff <= rv_in;
      wb_ff <= wb_in; x_ff <= x_in; y_ff <= y_in; prod_ff <= prod_in;
      q_ff <= q_in; rem_ff <= rem_in; cnt_ff <= cnt_in;
      onpc_ff <= onpc_in; owv_ff <= owv_in; owval_ff <= owval_in; ost_ff <= ost_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pl0_pkg::FSM_CLEAR:
            if (clr_ff == AW'(STACK_DEPTH - 1)) state_in = pl0_pkg::FSM_IDLE;
         pl0_pkg::FSM_IDLE:
            if (req.valid) begin
               if (halted_ff || pc_ff >= limit) state_in = pl0_pkg::FSM_OUT;
               else state_in = pl0_pkg::FSM_FINISH;
               if (!halted_ff && pc_ff < limit) begin
                  unique case (req.kind)
                     pl0_pkg::KIND_LOD, pl0_pkg::KIND_STO, pl0_pkg::KIND_RED:
                        state_in = pl0_pkg::FSM_WALK;
                     pl0_pkg::KIND_CAL: state_in = pl0_pkg::FSM_CALW;
                     pl0_pkg::KIND_OPR, pl0_pkg::KIND_JPC, pl0_pkg::KIND_WRT:
                        state_in = pl0_pkg::FSM_RD1;
                     default: state_in = pl0_pkg::FSM_FINISH;
                  endcase
               end
            end
         pl0_pkg::FSM_WALK: state_in = pl0_pkg::FSM_LINK;
         pl0_pkg::FSM_LINK: state_in = pl0_pkg::FSM_WALK;
         pl0_pkg::FSM_CALW: state_in = pl0_pkg::FSM_WALK;
         pl0_pkg::FSM_RD1: state_in = pl0_pkg::FSM_RD2;
         pl0_pkg::FSM_RD2: state_in = pl0_pkg::FSM_FINISH;
         pl0_pkg::FSM_RETB: state_in = pl0_pkg::FSM_FINISH;
         pl0_pkg::FSM_MUL: state_in = pl0_pkg::FSM_FINISH;
         pl0_pkg::FSM_DIV:
            if (cnt_ff == 6'd0) state_in = pl0_pkg::FSM_FINISH;
         pl0_pkg::FSM_FINISH: state_in = pl0_pkg::FSM_OUT;
         pl0_pkg::FSM_OUT:
            if (rsp.ready) state_in = pl0_pkg::FSM_IDLE;
         default: state_in = pl0_pkg::FSM_IDLE;
      endcase
      // datapath may redirect (walk end, errors, op dispatch)
      if (redirect_valid) state_in = redirect_state;
   end

   logic redirect_valid;
   pl0_pkg::fsm_type redirect_state;

   // datapath and outputs
   always_comb begin
      code_len_in = code_len_ff;
      if (csr.valid) code_len_in = csr.data;
      top_in = top_ff; base_in = base_ff; pc_in = pc_ff; halted_in = halted_ff;
      kind_in = kind_ff; lv_in = lv_ff; adr_in = adr_ff; rv_in = rv_ff;
      wb_in = wb_ff; x_in = x_ff; y_in = y_ff; prod_in = prod_ff;
      q_in = q_ff; rem_in = rem_ff; cnt_in = cnt_ff; clr_in = clr_ff;
      onpc_in = onpc_ff; owv_in = owv_ff; owval_in = owval_ff; ost_in = ost_ff;
      wr_en = 1'b0; wr_addr = '0; wr_data = '0; rd_addr = '0;
      redirect_valid = 1'b0; redirect_state = pl0_pkg::FSM_IDLE;

      unique case (state_ff)
         pl0_pkg::FSM_CLEAR: begin
            wr_en = 1'b1; wr_addr = clr_ff; clr_in = AW'(clr_ff + AW'(1));
         end
         pl0_pkg::FSM_IDLE: begin
            kind_in = req.kind; lv_in = req.level; adr_in = req.address;
            rv_in = req.read_value; wb_in = base_ff;
            owv_in = 1'b0; owval_in = '0; ost_in = pl0_pkg::ST_RUN;
            onpc_in = pc_ff;
            rd_addr = top_ff[AW-1:0];
            if (req.valid) begin
               if (halted_ff || pc_ff >= limit) begin
                  halted_in = 1'b1; ost_in = pl0_pkg::ST_END;
               end else if (req.kind == pl0_pkg::KIND_CAL) begin
                  if (top_ff + TW'(3) >= SDEPTH) begin
                     ost_in = pl0_pkg::ST_OVERFLOW;
                     redirect_valid = 1'b1; redirect_state = pl0_pkg::FSM_FINISH;
                  end else begin
                     wr_en = 1'b1; wr_addr = tp1[AW-1:0];
                     wr_data = 32'(pc_ff + PW'(1));
                  end
               end else if (req.kind == pl0_pkg::KIND_OPR
                            && req.address == pl0_pkg::OPR_RET) begin
                  if (32'(base_ff) + 32'd1 >= 32'(STACK_DEPTH)) begin
                     ost_in = pl0_pkg::ST_RANGE;
                     redirect_valid = 1'b1; redirect_state = pl0_pkg::FSM_FINISH;
                  end else begin
                     rd_addr = AW'(base_ff + AW'(1));
                  end
               end
            end
         end
         pl0_pkg::FSM_CALW: begin
            wr_en = 1'b1; wr_addr = AW'(tp1[AW-1:0] + AW'(1));
            wr_data = 32'(base_ff);
            rd_addr = AW'(wb_ff + AW'(2));
            if (lv_ff != 8'd0 && 32'(wb_ff) + 32'd2 >= 32'(STACK_DEPTH)) begin
               ost_in = pl0_pkg::ST_RANGE;
               redirect_valid = 1'b1; redirect_state = pl0_pkg::FSM_FINISH;
            end
         end
         pl0_pkg::FSM_WALK: begin
            rd_addr = AW'(wb_ff + AW'(2));
            if (lv_ff == 8'd0) begin
               redirect_valid = 1'b1;
               redirect_state = pl0_pkg::FSM_FINISH;
               if (kind_ff == pl0_pkg::KIND_LOD) begin
                  if (tp1 >= SDEPTH) ost_in = pl0_pkg::ST_OVERFLOW;
                  else if (!faddr_ok) ost_in = pl0_pkg::ST_RANGE;
                  else begin
                     rd_addr = faddr[AW-1:0]; redirect_state = pl0_pkg::FSM_RD2;
                  end
               end else if (kind_ff == pl0_pkg::KIND_STO) begin
                  if (top_ff < 0) ost_in = pl0_pkg::ST_RANGE;
                  else if (!faddr_ok) ost_in = pl0_pkg::ST_RANGE;
                  else begin
                     rd_addr = top_ff[AW-1:0]; redirect_state = pl0_pkg::FSM_RD2;
                  end
               end else if (kind_ff == pl0_pkg::KIND_RED) begin
                  if (!faddr_ok) ost_in = pl0_pkg::ST_RANGE;
               end
            end else if (32'(wb_ff) + 32'd2 >= 32'(STACK_DEPTH)) begin
               ost_in = pl0_pkg::ST_RANGE;
               redirect_valid = 1'b1; redirect_state = pl0_pkg::FSM_FINISH;
            end
            if (kind_ff == pl0_pkg::KIND_LOD && tp1 >= SDEPTH) begin
               ost_in = pl0_pkg::ST_OVERFLOW;
               redirect_valid = 1'b1; redirect_state = pl0_pkg::FSM_FINISH;
            end
            if (kind_ff == pl0_pkg::KIND_STO && top_ff < 0) begin
               ost_in = pl0_pkg::ST_RANGE;
               redirect_valid = 1'b1; redirect_state = pl0_pkg::FSM_FINISH;
            end
         end
         pl0_pkg::FSM_LINK: begin
            // follow one static link
            if (rd_data >= 32'(STACK_DEPTH)) begin
               ost_in = pl0_pkg::ST_RANGE;
               redirect_valid = 1'b1; redirect_state = pl0_pkg::FSM_FINISH;
            end
            wb_in = rd_data[AW-1:0];
            lv_in = lv_ff - 8'd1;
         end
         pl0_pkg::FSM_RD1: begin
            // rd_data: top (dynamic link for RET); fetch second operand or return frame
            y_in = rd_data;
            x_in = rd_data;
            if (kind_ff == pl0_pkg::KIND_OPR && adr_ff == pl0_pkg::OPR_RET) begin
               rd_addr = base_ff;
               redirect_valid = 1'b1; redirect_state = pl0_pkg::FSM_RETB;
            end else begin
               rd_addr = AW'(top_ff[AW-1:0] - AW'(1));
            end
         end
         pl0_pkg::FSM_RETB: begin
            x_in = rd_data; // return address
            // y_ff holds the dynamic link
         end
         pl0_pkg::FSM_RD2: begin
            // x: second from top (loaded value for LOD, top for STO), y: top
            x_in = rd_data;
            if (kind_ff == pl0_pkg::KIND_OPR) begin
               if (adr_ff == pl0_pkg::OPR_MUL) begin
                  redirect_valid = 1'b1; redirect_state = pl0_pkg::FSM_MUL;
               end else if (adr_ff == pl0_pkg::OPR_DIV && top_ff >= TW'(1)
                            && y_ff != 32'd0) begin
                  redirect_valid = 1'b1; redirect_state = pl0_pkg::FSM_DIV;
                  cnt_in = 6'd31; rem_in = '0; q_in = '0;
               end
            end
         end
         pl0_pkg::FSM_MUL: prod_in = x_ff * y_ff;
         pl0_pkg::FSM_DIV: begin
            // restoring division, one quotient bit a cycle
            if (!rtrial[32]) begin
               rem_in = rtrial[31:0]; q_in = {q_ff[30:0], 1'b1};
            end else begin
               rem_in = {rem_ff[30:0], ma[cnt_ff[4:0]]}; q_in = {q_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff - 6'd1;
         end
         pl0_pkg::FSM_FINISH: begin
            logic [PW-1:0] p;
            logic signed [TW-1:0] t;
            logic [AW-1:0] b;
            logic [2:0] st;
            logic ret;
            p = pc_ff + PW'(1); t = top_ff; b = base_ff; st = ost_ff; ret = 1'b0;
            if (st == pl0_pkg::ST_RUN) begin
               unique case (kind_ff)
                  pl0_pkg::KIND_LIT: begin
                     if (tp1 >= SDEPTH) st = pl0_pkg::ST_OVERFLOW;
                     else begin
                        t = tp1; wr_en = 1'b1; wr_addr = tp1[AW-1:0]; wr_data = adr_ff;
                     end
                  end
                  pl0_pkg::KIND_LOD: begin
                     t = tp1; wr_en = 1'b1; wr_addr = tp1[AW-1:0]; wr_data = x_ff;
                  end
                  pl0_pkg::KIND_STO: begin
                     t = top_ff - TW'(1); wr_en = 1'b1; wr_addr = faddr[AW-1:0];
                     wr_data = x_ff;
                  end
                  pl0_pkg::KIND_RED: begin
                     wr_en = 1'b1; wr_addr = faddr[AW-1:0]; wr_data = rv_ff;
                  end
                  pl0_pkg::KIND_CAL: begin
                     wr_en = 1'b1; wr_addr = AW'(tp1[AW-1:0] + AW'(2));
                     wr_data = 32'(wb_ff);
                     b = tp1[AW-1:0]; p = tgt(adr_ff);
                  end
                  pl0_pkg::KIND_INT: begin
                     if (nt >= 34'(STACK_DEPTH)) st = pl0_pkg::ST_OVERFLOW;
                     else if (nt < -34'sd1) st = pl0_pkg::ST_RANGE;
                     else t = TW'(nt);
                  end
                  pl0_pkg::KIND_JMP: p = tgt(adr_ff);
                  pl0_pkg::KIND_JPC: begin
                     if (top_ff < 0) st = pl0_pkg::ST_RANGE;
                     else begin
                        if (y_ff == 32'd0) p = tgt(adr_ff);
                        t = top_ff - TW'(1);
                     end
                  end
                  pl0_pkg::KIND_WRT: begin
                     if (top_ff < 0) st = pl0_pkg::ST_RANGE;
                     else begin
                        owv_in = 1'b1; owval_in = y_ff; t = top_ff - TW'(1);
                     end
                  end
                  pl0_pkg::KIND_OPR: begin
                     case (adr_ff)
                        pl0_pkg::OPR_RET: begin
                           if (y_ff >= 32'(STACK_DEPTH)) st = pl0_pkg::ST_RANGE;
                           else begin
                              t = $signed({2'b00, base_ff}) - TW'(1);
                              p = tgt(x_ff); b = y_ff[AW-1:0]; ret = 1'b1;
                           end
                        end
                        pl0_pkg::OPR_NEG, pl0_pkg::OPR_ODD: begin
                           if (top_ff < 0) st = pl0_pkg::ST_RANGE;
                           else begin
                              wr_en = 1'b1; wr_addr = top_ff[AW-1:0];
                              wr_data = (adr_ff == pl0_pkg::OPR_NEG) ? 32'(0 - y_ff)
                                                                     : {31'd0, y_ff[0]};
                           end
                        end
                        pl0_pkg::OPR_ADD, pl0_pkg::OPR_SUB, pl0_pkg::OPR_MUL,
                        pl0_pkg::OPR_DIV, pl0_pkg::OPR_EQL, pl0_pkg::OPR_NEQ,
                        pl0_pkg::OPR_LSS, pl0_pkg::OPR_GEQ, pl0_pkg::OPR_GTR,
                        pl0_pkg::OPR_LEQ: begin
                           if (top_ff < TW'(1)) st = pl0_pkg::ST_RANGE;
                           else if (adr_ff == pl0_pkg::OPR_DIV && y_ff == 32'd0)
                              st = pl0_pkg::ST_DIVZERO;
                           else begin
                              t = top_ff - TW'(1);
                              wr_en = 1'b1; wr_addr = t[AW-1:0];
                              case (adr_ff)
                                 pl0_pkg::OPR_ADD: wr_data = x_ff + y_ff;
                                 pl0_pkg::OPR_SUB: wr_data = x_ff - y_ff;
                                 pl0_pkg::OPR_MUL: wr_data = prod_ff[31:0];
                                 pl0_pkg::OPR_DIV:
                                    wr_data = (x_ff[31] ^ y_ff[31]) ? 32'(0 - q_ff) : q_ff;
                                 pl0_pkg::OPR_EQL: wr_data = {31'd0, x_ff == y_ff};
                                 pl0_pkg::OPR_NEQ: wr_data = {31'd0, x_ff != y_ff};
                                 pl0_pkg::OPR_LSS: wr_data = {31'd0, slt_xy};
                                 pl0_pkg::OPR_GEQ: wr_data = {31'd0, !slt_xy};
                                 pl0_pkg::OPR_GTR: wr_data = {31'd0, slt_yx};
                                 default:          wr_data = {31'd0, !slt_yx};
                              endcase
                           end
                        end
                        default: st = pl0_pkg::ST_BADOP;
                     endcase
                  end
                  default: st = pl0_pkg::ST_BADOP;
               endcase
            end
            if (st == pl0_pkg::ST_RUN) begin
               top_in = t; base_in = b; pc_in = p; onpc_in = p;
               if ((ret && t < 0) || p >= limit) begin
                  halted_in = 1'b1; st = pl0_pkg::ST_END;
               end
            end else begin
               // cancel the write of this state, hold the old state
               wr_en = 1'b0;
               halted_in = 1'b1; owv_in = 1'b0; owval_in = '0; onpc_in = pc_ff;
            end
            ost_in = st;
         end
         pl0_pkg::FSM_OUT: ;
         default: ;
      endcase
   end
endmodule

// ===== src/pl0_ram.sv =====
module pl0_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== dv/pl0_pcode_checker.sv =====
module pl0_pcode_checker
   import pl0_pkg::*;
(
   input  logic clock,
   input  logic reset,
   pl0_req_if   req_bus,
   pl0_rsp_if   rsp_bus,
   pl0_csr_if   csr_bus,
   output int   fail_count,
   output int   pending
);

   localparam int unsigned STACK_WORDS = 1024;
   localparam int unsigned CODE_WORDS  = 4096;

   typedef struct packed {
      logic [12:0] next_pc;
      logic        write_valid;
      logic [31:0] write_value;
      logic [2:0]  status;
   } instr_result_t;

   logic [31:0]   stack_mem [STACK_WORDS];
   int            stack_top;
   int unsigned   cur_base;
   int unsigned   cur_pc;
   bit            is_halted;
   logic [12:0]   code_len;
   instr_result_t result_q[$];

   function automatic int unsigned jump_target(longint v);
      return (v >= 0 && v < CODE_WORDS) ? int'(v) : CODE_WORDS;
   endfunction

   // follow the static chain lv times starting at frame b
   function automatic logic [2:0] chain_walk(input int unsigned b, input int unsigned lv,
                                             output int unsigned res);
      logic [31:0] link;
      res = 0;
      while (lv > 0) begin
         if (b + 2 >= STACK_WORDS) return ST_RANGE;
         link = stack_mem[b + 2];
         if (link >= STACK_WORDS) return ST_RANGE;
         b = link;
         lv--;
      end
      res = b;
      return ST_RUN;
   endfunction

   function automatic logic [2:0] frame_slot(input int unsigned b, input int unsigned lv,
                                             input longint off, output int unsigned res);
      int unsigned fb;
      longint      slot;
      logic [2:0]  st;
      res = 0;
      st = chain_walk(b, lv, fb);
      if (st != ST_RUN) return st;
      slot = longint'(fb) + off;
      if (slot < 0 || slot >= STACK_WORDS) return ST_RANGE;
      res = int'(slot);
      return ST_RUN;
   endfunction

   function automatic logic [31:0] div_trunc(logic [31:0] a, logic [31:0] b);
      logic [31:0] ma, mb, q;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q = ma / mb;
      return (a[31] ^ b[31]) ? -q : q;
   endfunction

   task automatic execute(input logic [3:0] k, input logic [7:0] lv, input logic [31:0] adr,
                          input logic [31:0] rv, output instr_result_t r);
      longint      sadr;
      longint      nt;
      int          t;
      int unsigned b, p, slot, nb, sl, limit;
      logic [2:0]  st;
      bit          ret_done, wv;
      logic [31:0] wval, x, y, rr;
      sadr = longint'($signed(adr));
      limit = (code_len < CODE_WORDS) ? code_len : CODE_WORDS;
      st = ST_RUN;
      wv = 1'b0;
      wval = '0;
      if (is_halted) begin
         st = ST_END;
      end else if (cur_pc >= limit) begin
         is_halted = 1'b1;
         st = ST_END;
      end else begin
         t = stack_top;
         b = cur_base;
         p = cur_pc + 1;
         ret_done = 1'b0;
         rr = '0;
         case (k)
            KIND_LIT: begin
               if (t + 1 >= STACK_WORDS) st = ST_OVERFLOW;
               else begin
                  t++;
                  stack_mem[t] = adr;
               end
            end
            KIND_OPR: begin
               case (adr)
                  OPR_RET: begin
                     if (b + 1 >= STACK_WORDS) st = ST_RANGE;
                     else begin
                        nb = stack_mem[b + 1];
                        if (stack_mem[b + 1] >= STACK_WORDS) st = ST_RANGE;
                        else begin
                           t = int'(b) - 1;
                           p = jump_target(longint'($signed(stack_mem[b])));
                           b = nb;
                           ret_done = 1'b1;
                        end
                     end
                  end
                  OPR_NEG, OPR_ODD: begin
                     if (t < 0) st = ST_RANGE;
                     else if (adr == OPR_NEG) stack_mem[t] = -stack_mem[t];
                     else stack_mem[t] = {31'd0, stack_mem[t][0]};
                  end
                  OPR_ADD, OPR_SUB, OPR_MUL, OPR_DIV, OPR_EQL, OPR_NEQ,
                  OPR_LSS, OPR_GEQ, OPR_GTR, OPR_LEQ: begin
                     if (t < 1) st = ST_RANGE;
                     else begin
                        x = stack_mem[t - 1];
                        y = stack_mem[t];
                        case (adr)
                           OPR_ADD: rr = x + y;
                           OPR_SUB: rr = x - y;
                           OPR_MUL: rr = x * y;
                           OPR_DIV: begin
                              if (y == 0) st = ST_DIVZERO;
                              else rr = div_trunc(x, y);
                           end
                           OPR_EQL: rr = 32'(x == y);
                           OPR_NEQ: rr = 32'(x != y);
                           OPR_LSS: rr = 32'($signed(x) < $signed(y));
                           OPR_GEQ: rr = 32'($signed(x) >= $signed(y));
                           OPR_GTR: rr = 32'($signed(y) < $signed(x));
                           default: rr = 32'($signed(y) >= $signed(x));
                        endcase
                        if (st == ST_RUN) begin
                           t--;
                           stack_mem[t] = rr;
                        end
                     end
                  end
                  default: st = ST_BADOP;
               endcase
            end
            KIND_LOD: begin
               if (t + 1 >= STACK_WORDS) st = ST_OVERFLOW;
               else begin
                  st = frame_slot(b, lv, sadr, slot);
                  if (st == ST_RUN) begin
                     t++;
                     stack_mem[t] = stack_mem[slot];
                  end
               end
            end
            KIND_STO, KIND_RED: begin
               if (k == KIND_STO && t < 0) st = ST_RANGE;
               else begin
                  st = frame_slot(b, lv, sadr, slot);
                  if (st == ST_RUN) begin
                     if (k == KIND_STO) begin
                        stack_mem[slot] = stack_mem[t];
                        t--;
                     end else begin
                        stack_mem[slot] = rv;
                     end
                  end
               end
            end
            KIND_CAL: begin
               if (t + 3 >= STACK_WORDS) st = ST_OVERFLOW;
               else begin
                  // link words stay written even when the chain walk faults
                  stack_mem[t + 1] = p;
                  stack_mem[t + 2] = b;
                  st = chain_walk(b, lv, sl);
                  if (st == ST_RUN) begin
                     stack_mem[t + 3] = sl;
                     b = t + 1;
                     p = jump_target(sadr);
                  end
               end
            end
            KIND_INT: begin
               nt = longint'(t) + sadr;
               if (nt >= STACK_WORDS) st = ST_OVERFLOW;
               else if (nt < -1) st = ST_RANGE;
               else t = int'(nt);
            end
            KIND_JMP: p = jump_target(sadr);
            KIND_JPC: begin
               if (t < 0) st = ST_RANGE;
               else begin
                  if (stack_mem[t] == 0) p = jump_target(sadr);
                  t--;
               end
            end
            KIND_WRT: begin
               if (t < 0) st = ST_RANGE;
               else begin
                  wv = 1'b1;
                  wval = stack_mem[t];
                  t--;
               end
            end
            default: st = ST_BADOP;
         endcase
         if (st == ST_RUN) begin
            stack_top = t;
            cur_base = b;
            cur_pc = p;
            if ((ret_done && t < 0) || p >= limit) begin
               is_halted = 1'b1;
               st = ST_END;
            end
         end else begin
            is_halted = 1'b1;
            wv = 1'b0;
            wval = '0;
         end
      end
      r.next_pc = cur_pc[12:0];
      r.write_valid = wv;
      r.write_value = wval;
      r.status = st;
   endtask

   always @(posedge clock) begin
      instr_result_t exp_r, got_r;
      if (reset) begin
         foreach (stack_mem[i]) stack_mem[i] = '0;
         stack_top = -1;
         cur_base = 0;
         cur_pc = 0;
         is_halted = 1'b0;
         code_len = '0;
         result_q.delete();
         fail_count = 0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) code_len = csr_bus.data;
         if (req_bus.valid && req_bus.ready) begin
            execute(req_bus.kind, req_bus.level, req_bus.address, req_bus.read_value, exp_r);
            result_q.push_back(exp_r);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got_r.next_pc = rsp_bus.next_pc;
            got_r.write_valid = rsp_bus.write_valid;
            got_r.write_value = rsp_bus.write_value;
            got_r.status = rsp_bus.status;
            if (result_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected response transaction: pc=%0d wv=%0b wval=%h st=%0d",
                           got_r.next_pc, got_r.write_valid, got_r.write_value, got_r.status);
            end else begin
               exp_r = result_q.pop_front();
               if (got_r !== exp_r) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: exp pc=%0d wv=%0b wval=%h st=%0d, got pc=%0d wv=%0b wval=%h st=%0d",
                              exp_r.next_pc, exp_r.write_valid, exp_r.write_value, exp_r.status,
                              got_r.next_pc, got_r.write_valid, got_r.write_value, got_r.status);
               end
            end
         end
      end
      pending = result_q.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
   end

endmodule

// ===== dv/tb_pl0_pcode_stack_machine_top.sv =====
module tb_pl0_pcode_stack_machine_top;
   import pl0_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;

   logic clock = 1'b0;
   logic reset;
   int   fail_count;
   int   pending;
   int   cycle_count = 0;
   int   gen_pc;
   int   call_depth;
   int   ret_pc_q[$];
   bit   sender_busy_free;
   bit   recv_busy_free;
   int   rsp_count = 0;

   pl0_req_if req_bus();
   pl0_rsp_if rsp_bus();
   pl0_csr_if csr_bus();

   pl0_pcode_stack_machine_top uut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   pl0_pcode_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .csr_bus    (csr_bus),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 5))
         0: return 32'h0000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h8000_0000;
         3: return 32'hffff_ffff;
         4: return 32'($urandom_range(0, 20));
         default: return $urandom;
      endcase
   endfunction

   // offer one instruction; returns at the edge where it is taken
   task automatic send_instr(input logic [3:0] k, input logic [7:0] lv,
                             input logic [31:0] adr, input logic [31:0] rv);
      int gap;
      gap = sender_busy_free ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.kind       <= k;
      req_bus.level      <= lv;
      req_bus.address    <= adr;
      req_bus.read_value <= rv;
      @(negedge clock);
      while (!req_bus.ready) @(negedge clock);
      @(posedge clock);
      gen_pc++;
   endtask

   task automatic write_code_length(input logic [12:0] len);
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (8) @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= len;
      @(negedge clock);
      while (!csr_bus.ready) @(negedge clock);
      @(posedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic binary_op(input logic [31:0] a, input logic [31:0] b, input logic [31:0] op);
      send_instr(KIND_LIT, 8'd0, a, $urandom);
      send_instr(KIND_LIT, 8'd0, b, $urandom);
      send_instr(KIND_OPR, 8'd0, op, $urandom);
      send_instr(KIND_WRT, 8'd0, 32'd0, $urandom);
   endtask

   // stack-neutral fragments, so the machine keeps running through the phase
   task automatic random_fragment();
      logic [31:0] opr_list [10];
      logic [31:0] op, b;
      int lv, off, tgt, n;
      opr_list = '{OPR_ADD, OPR_SUB, OPR_MUL, OPR_DIV, OPR_EQL,
                   OPR_NEQ, OPR_LSS, OPR_GEQ, OPR_GTR, OPR_LEQ};
      if (gen_pc > 120) begin
         tgt = $urandom_range(0, 40);
         send_instr(KIND_JMP, 8'd0, tgt, $urandom);
         gen_pc = tgt;
      end
      lv = $urandom_range(0, call_depth);
      off = (lv == call_depth) ? $urandom_range(3, 7) : 3;
      case ($urandom_range(0, 9))
         0: begin
            op = opr_list[$urandom_range(0, 9)];
            b = pick_word();
            if (op == OPR_DIV && b == 0) b = 32'd1;
            binary_op(pick_word(), b, op);
         end
         1: begin
            send_instr(KIND_LIT, 8'd0, pick_word(), $urandom);
            send_instr(KIND_OPR, 8'd0, $urandom_range(0, 1) ? OPR_NEG : OPR_ODD, $urandom);
            send_instr(KIND_WRT, 8'd0, 32'd0, $urandom);
         end
         2: begin
            send_instr(KIND_LIT, 8'd0, pick_word(), $urandom);
            send_instr(KIND_STO, lv, off, $urandom);
            send_instr(KIND_LOD, lv, off, $urandom);
            send_instr(KIND_WRT, 8'd0, 32'd0, $urandom);
         end
         3: begin
            send_instr(KIND_RED, lv, off, pick_word());
            send_instr(KIND_LOD, lv, off, $urandom);
            send_instr(KIND_WRT, 8'd0, 32'd0, $urandom);
         end
         4: begin
            send_instr(KIND_LIT, 8'd0, $urandom_range(0, 1) ? 32'd0 : pick_word(), $urandom);
            send_instr(KIND_JPC, 8'd0, gen_pc + 1, $urandom);
         end
         5: begin
            tgt = $urandom_range(0, 40);
            send_instr(KIND_JMP, 8'd0, tgt, $urandom);
            gen_pc = tgt;
         end
         6: begin
            if (call_depth < 3) begin
               ret_pc_q.push_back(gen_pc + 1);
               send_instr(KIND_CAL, 8'd0, gen_pc + 1, $urandom);
               call_depth++;
               send_instr(KIND_INT, 8'd0, 32'd4, $urandom);
            end
         end
         7: begin
            if (call_depth > 0) begin
               send_instr(KIND_OPR, 8'd0, OPR_RET, $urandom);
               gen_pc = ret_pc_q.pop_back();
               call_depth--;
            end
         end
         8: begin
            n = $urandom_range(0, 5);
            send_instr(KIND_INT, 8'd0, n, $urandom);
            send_instr(KIND_INT, 8'd0, -n, $urandom);
         end
         default: begin
            send_instr(KIND_LIT, 8'd0, pick_word(), $urandom);
            send_instr(KIND_WRT, 8'd0, 32'd0, $urandom);
         end
      endcase
   endtask

   task automatic noise_items(input int count);
      repeat (count)
         send_instr($urandom_range(0, 15), $urandom,
                    $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 14)), $urandom);
   endtask

   // response side: random stalls, one long hold to back up the block
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      recv_busy_free = 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_count % 64 == 0) recv_busy_free = ($urandom_range(0, 3) == 0);
         stall = recv_busy_free ? 0 : $urandom_range(0, 9);
         if (rsp_count == 150) stall = 500;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(negedge clock);
         while (!rsp_bus.valid) @(negedge clock);
         @(posedge clock);
         rsp_count++;
      end
   end

   initial begin
      logic [12:0] phase_len [3];
      int sent;
      phase_len = '{13'd8191, 13'd200, 13'd4096};
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.kind = '0;
      req_bus.level = '0;
      req_bus.address = '0;
      req_bus.read_value = '0;
      csr_bus.valid = 1'b0;
      csr_bus.data = '0;
      sender_busy_free = 1'b0;
      gen_pc = 0;
      call_depth = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      write_code_length(13'd4096);
      send_instr(KIND_INT, 8'd0, 32'd8, 32'hffff_ffff);
      binary_op(32'h7fff_ffff, 32'd1, OPR_ADD);
      binary_op(32'h8000_0000, 32'hffff_ffff, OPR_DIV);
      binary_op(32'hffff_fff9, 32'd2, OPR_DIV);
      binary_op(32'h8000_0000, 32'h7fff_ffff, OPR_LSS);
      send_instr(KIND_LIT, 8'd0, 32'hffff_fffd, 32'd0);
      send_instr(KIND_OPR, 8'd0, OPR_ODD, 32'd0);
      send_instr(KIND_WRT, 8'd0, 32'd0, 32'd0);
      send_instr(KIND_JMP, 8'd0, 32'd4095, 32'd0);
      send_instr(KIND_JMP, 8'd0, 32'd0, 32'd0);
      gen_pc = 0;

      foreach (phase_len[i]) begin
         write_code_length(phase_len[i]);
         sent = 0;
         while (sent < 470) begin
            if (sent % 60 < 4) sender_busy_free = ($urandom_range(0, 3) == 0);
            random_fragment();
            sent += 3;
         end
      end

      // drive the machine into its halted state
      sender_busy_free = 1'b0;
      if ($urandom_range(0, 1)) begin
         write_code_length(13'd0);
         noise_items(40);
      end else begin
         noise_items(40);
         write_code_length(13'd0);
         noise_items(10);
      end

      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
